// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Software timer table package
// Request kinds, result status codes, controller states and the control
// group that the controller drives into every timer cell.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int KIND_W   = 3;
  localparam int AMOUNT_W = 24;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ONESHOT   = 3'd0,
    KIND_REPEAT    = 3'd1,
    KIND_NEXT_TICK = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_CLEAR_ALL = 3'd4,
    KIND_TICK      = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SET_OK      = 3'd0,
    ST_SET_FULL    = 3'd1,
    ST_CLEARED     = 3'd2,
    ST_NO_MATCH    = 3'd3,
    ST_ALL_CLEARED = 3'd4,
    ST_FIRED       = 3'd5,
    ST_TICK_DONE   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROTATE,
    S_RESP,
    S_COMPACT
  } state_t;

  typedef struct packed {
    logic shift;
    logic compact;
    logic clear_all;
    logic set_we;
  } cell_ctrl_t;

endpackage

// ===== hdl/stt_req_if.sv =====
// ----------------------------------------------------------------------------
// Timer request channel
// Carries one request item with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface stt_req_if;
  logic                          valid;
  logic                          ready;
  logic [stt_pkg::KIND_W-1:0]    kind;
  logic [stt_pkg::AMOUNT_W-1:0]  amount;
  logic [stt_pkg::HANDLE_W-1:0]  handle_in;

  modport source (output valid, kind, amount, handle_in, input ready);
  modport sink (input valid, kind, amount, handle_in, output ready);
endinterface

// ===== hdl/stt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Timer result channel
// Carries one result item with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [stt_pkg::STATUS_W-1:0]  status;
  logic [stt_pkg::HANDLE_W-1:0]  handle_out;
  logic                          last;

  modport source (output valid, status, handle_out, last, input ready);
  modport sink (input valid, status, handle_out, last, output ready);
endinterface

// ===== hdl/stt_cell.sv =====
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer entry. It shifts in its upper neighbor during a rotation,
// slides toward the head into an empty neighbor during compaction, and takes
// a new timer when it is the first free entry.
// ----------------------------------------------------------------------------
module stt_cell #(
  parameter int TIME_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  stt_pkg::cell_ctrl_t             ctrl,
  input  logic                            prv_used,
  input  logic                            nxt_used,
  input  logic [stt_pkg::HANDLE_W-1:0]    nxt_handle,
  input  logic [TIME_BITS-1:0]            nxt_rem,
  input  logic [TIME_BITS-1:0]            nxt_ival,
  input  logic                            nxt_rep,
  input  logic [stt_pkg::HANDLE_W-1:0]    set_handle,
  input  logic [TIME_BITS-1:0]            set_rem,
  input  logic [TIME_BITS-1:0]            set_ival,
  input  logic                            set_rep,
  output logic                            used,
  output logic [stt_pkg::HANDLE_W-1:0]    handle,
  output logic [TIME_BITS-1:0]            rem,
  output logic [TIME_BITS-1:0]            ival,
  output logic                            rep
);

  logic take_nxt;
  logic take_set;

  assign take_nxt = ctrl.shift || (ctrl.compact && !used && nxt_used);
  assign take_set = ctrl.set_we && !used && prv_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clear_all) begin
      used <= 1'b0;
    end else if (ctrl.shift) begin
      used <= nxt_used;
    end else if (ctrl.compact) begin
      if (!used) begin
        used <= nxt_used;
      end else if (!prv_used) begin
        used <= 1'b0;
      end
    end else if (take_set) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_nxt) begin
      handle <= nxt_handle;
      rem    <= nxt_rem;
      ival   <= nxt_ival;
      rep    <= nxt_rep;
    end else if (take_set) begin
      handle <= set_handle;
      rem    <= set_rem;
      ival   <= set_ival;
      rep    <= set_rep;
    end
  end

endmodule

// ===== hdl/software_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// Software timer table core
// Keeps timers oldest first in a chain of cells, assigns handles, clears
// timers and reports the timers that expire on each tick.
//
//   Channel  Direction  Item
//   req      in         kind, amount, handle_in
//   rsp      out        status, handle_out, last
//
// A set or a clear-all acts on the cells, then reports its result. A clear or
// a tick rotates the whole chain once through the head cell, one entry a
// cycle while no fire report is stalled on rsp, then reports its result and
// compacts the chain. Reset empties the table and sets the next handle to one.
// Only one request is in work at a time; a result waits in the output register.
// ----------------------------------------------------------------------------
module software_timer_table_core #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 24
) (
  input logic        clk,
  input logic        rst,
  stt_req_if.sink    req,
  stt_rsp_if.source  rsp
);

  localparam int CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  stt_pkg::state_t     state;
  stt_pkg::state_t     state_next;
  stt_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0]             cnt;
  logic                         cnt_inc;
  logic                         cnt_last;
  logic [stt_pkg::KIND_W-1:0]   op_kind;
  logic [TIME_BITS-1:0]         op_amount;
  logic [stt_pkg::HANDLE_W-1:0] op_handle;
  logic                         found;
  logic [stt_pkg::HANDLE_W-1:0] next_handle;
  stt_pkg::status_t             resp_status;
  logic [stt_pkg::HANDLE_W-1:0] resp_handle;

  logic                         o_valid;
  stt_pkg::status_t             o_status;
  logic [stt_pkg::HANDLE_W-1:0] o_handle;
  logic                         o_last;

  logic                         accept;
  logic                         full;
  logic                         is_set;
  logic                         is_tick;
  logic                         rotate_op;
  logic                         fire;
  logic                         match;
  logic                         step_go;
  logic                         emit;
  logic                         emit_ok;
  stt_pkg::status_t             emit_status;
  logic [stt_pkg::HANDLE_W-1:0] emit_handle;
  logic                         emit_last;

  logic [TIME_BITS-1:0]         amt_in;
  logic [TIME_BITS-1:0]         set_rem;
  logic [TIME_BITS-1:0]         set_ival;
  logic                         set_rep;

  logic                         c_used   [NUM_TIMERS];
  logic [stt_pkg::HANDLE_W-1:0] c_handle [NUM_TIMERS];
  logic [TIME_BITS-1:0]         c_rem    [NUM_TIMERS];
  logic [TIME_BITS-1:0]         c_ival   [NUM_TIMERS];
  logic                         c_rep    [NUM_TIMERS];

  logic                         f_used;
  logic [TIME_BITS-1:0]         f_rem;

  assign accept   = req.valid && req.ready;
  assign full     = c_used[NUM_TIMERS-1];
  assign cnt_last = (cnt == CNT_W'(NUM_TIMERS - 1));
  assign emit_ok  = !o_valid || rsp.ready;

  assign is_set    = (req.kind == stt_pkg::KIND_ONESHOT) || (req.kind == stt_pkg::KIND_REPEAT)
                     || (req.kind == stt_pkg::KIND_NEXT_TICK);
  assign is_tick   = (op_kind == stt_pkg::KIND_TICK);
  assign rotate_op = is_tick || (op_kind == stt_pkg::KIND_CLEAR);

  assign amt_in   = TIME_BITS'(req.amount);
  assign set_rem  = (req.kind == stt_pkg::KIND_NEXT_TICK) ? '0 : amt_in;
  assign set_rep  = (req.kind == stt_pkg::KIND_REPEAT);
  assign set_ival = set_rep ? amt_in : '0;

  // The head cell is examined on each rotation step and written back at the tail.
  assign fire    = is_tick && c_used[0] && (op_amount >= c_rem[0]);
  assign match   = (op_kind == stt_pkg::KIND_CLEAR) && c_used[0] && !found
                   && (op_handle != '0) && (c_handle[0] == op_handle);
  assign step_go = !fire || emit_ok;
  assign f_used  = c_used[0] && !match && !(fire && !c_rep[0]);
  assign f_rem   = fire ? c_ival[0] : ((is_tick && c_used[0]) ? c_rem[0] - op_amount : c_rem[0]);

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic                         n_used;
    logic [stt_pkg::HANDLE_W-1:0] n_handle;
    logic [TIME_BITS-1:0]         n_rem;
    logic [TIME_BITS-1:0]         n_ival;
    logic                         n_rep;
    logic                         p_used;

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign n_used   = ctrl.shift ? f_used : 1'b0;
      assign n_handle = c_handle[0];
      assign n_rem    = f_rem;
      assign n_ival   = c_ival[0];
      assign n_rep    = c_rep[0];
    end else begin : g_body
      assign n_used   = c_used[i+1];
      assign n_handle = c_handle[i+1];
      assign n_rem    = c_rem[i+1];
      assign n_ival   = c_ival[i+1];
      assign n_rep    = c_rep[i+1];
    end

    if (i == 0) begin : g_head
      assign p_used = 1'b1;
    end else begin : g_prev
      assign p_used = c_used[i-1];
    end

    stt_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prv_used   (p_used),
      .nxt_used   (n_used),
      .nxt_handle (n_handle),
      .nxt_rem    (n_rem),
      .nxt_ival   (n_ival),
      .nxt_rep    (n_rep),
      .set_handle (next_handle),
      .set_rem    (set_rem),
      .set_ival   (set_ival),
      .set_rep    (set_rep),
      .used       (c_used[i]),
      .handle     (c_handle[i]),
      .rem        (c_rem[i]),
      .ival       (c_ival[i]),
      .rep        (c_rep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctrl        = '0;
    cnt_inc     = 1'b0;
    emit        = 1'b0;
    emit_status = stt_pkg::ST_FIRED;
    emit_handle = '0;
    emit_last   = 1'b0;
    req.ready   = 1'b0;
    unique case (state)
      stt_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          unique case (req.kind)
            stt_pkg::KIND_ONESHOT, stt_pkg::KIND_REPEAT, stt_pkg::KIND_NEXT_TICK: begin
              ctrl.set_we = !full;
              state_next  = stt_pkg::S_RESP;
            end
            stt_pkg::KIND_CLEAR, stt_pkg::KIND_TICK: begin
              state_next = stt_pkg::S_ROTATE;
            end
            stt_pkg::KIND_CLEAR_ALL: begin
              ctrl.clear_all = 1'b1;
              state_next     = stt_pkg::S_RESP;
            end
            default: begin
              state_next = stt_pkg::S_IDLE;
            end
          endcase
        end
      end
      stt_pkg::S_ROTATE: begin
        emit        = fire;
        emit_handle = c_handle[0];
        ctrl.shift  = step_go;
        cnt_inc     = step_go;
        if (step_go && cnt_last) begin
          state_next = stt_pkg::S_RESP;
        end
      end
      stt_pkg::S_RESP: begin
        emit        = 1'b1;
        emit_status = resp_status;
        emit_handle = resp_handle;
        emit_last   = 1'b1;
        if (emit_ok) begin
          state_next = rotate_op ? stt_pkg::S_COMPACT : stt_pkg::S_IDLE;
        end
      end
      stt_pkg::S_COMPACT: begin
        ctrl.compact = 1'b1;
        cnt_inc      = 1'b1;
        if (cnt_last) begin
          state_next = stt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= req.kind;
      op_amount <= amt_in;
      op_handle <= req.handle_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (ctrl.shift && match) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_handle <= stt_pkg::HANDLE_W'(1);
    end else if (accept && is_set && !full) begin
      next_handle <= (next_handle == '1) ? stt_pkg::HANDLE_W'(1)
                                         : next_handle + stt_pkg::HANDLE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_set) begin
        resp_status <= full ? stt_pkg::ST_SET_FULL : stt_pkg::ST_SET_OK;
        resp_handle <= full ? '0 : next_handle;
      end else begin
        resp_status <= stt_pkg::ST_ALL_CLEARED;
        resp_handle <= '0;
      end
    end else if (ctrl.shift && cnt_last) begin
      resp_handle <= '0;
      if (is_tick) begin
        resp_status <= stt_pkg::ST_TICK_DONE;
      end else if (found || match) begin
        resp_status <= stt_pkg::ST_CLEARED;
      end else begin
        resp_status <= stt_pkg::ST_NO_MATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit && emit_ok) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && emit_ok) begin
      o_status <= emit_status;
      o_handle <= emit_handle;
      o_last   <= emit_last;
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.status     = o_status;
  assign rsp.handle_out = o_handle;
  assign rsp.last       = o_last;

endmodule

// ===== hdl/stt_checker.sv =====
// ----------------------------------------------------------------------------
// Software timer table checker
// Watches the ports of the core and checks result framing and the
// request handshake over time.
// ----------------------------------------------------------------------------
module stt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [stt_pkg::KIND_W-1:0]   req_kind,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [stt_pkg::STATUS_W-1:0] rsp_status,
  input logic [stt_pkg::HANDLE_W-1:0] rsp_handle,
  input logic                         rsp_last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_fire_frame: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == stt_pkg::ST_FIRED) |-> !rsp_last && (rsp_handle != '0))
    else $error("fire report must carry a handle and not close the request");

  a_close_frame: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != stt_pkg::ST_FIRED) |-> rsp_last)
    else $error("non-fire result must be the final item of its request");

  a_set_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == stt_pkg::ST_SET_OK) |-> (rsp_handle != '0))
    else $error("accepted set returned handle zero");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_kind <= stt_pkg::KIND_TICK) |=> !req_ready)
    else $error("new request taken while one is in work");

endmodule

bind software_timer_table_core stt_checker u_stt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_kind   (req.kind),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_handle (rsp.handle_out),
  .rsp_last   (rsp.last)
);
